// File: hdl/epp_pkg.sv
// Shared types, constants and state codes for the encounter-plane projection block.
package epp_pkg;

    localparam int SLOT_BITS  = 5;
    localparam int SLOT_COUNT = 31;
    localparam int RAD_SLOT   = 30;
    localparam int PAIR_COUNT = 15;
    localparam int UNIT_BITS  = 28;
    localparam int NORM_BITS  = 40;

    typedef logic signed [63:0]  t_s64;
    typedef logic signed [31:0]  t_s32;
    typedef logic signed [127:0] t_s128;
    typedef logic [127:0]        t_u128;

    typedef struct packed {
        logic start;
        t_s64 a;
        t_s64 b;
    } t_mul_req;

    typedef struct packed {
        logic  done;
        t_s128 p;
    } t_mul_rsp;

    typedef struct packed {
        logic        start;
        logic        is_div;
        t_u128       src;
        logic [63:0] den;
    } t_sd_req;

    typedef struct packed {
        logic        done;
        logic [63:0] res;
    } t_sd_rsp;

    typedef enum logic [1:0] {
        PASS_Z,
        PASS_X,
        PASS_DEG
    } t_pass;

    typedef enum logic [4:0] {
        S_IDLE,
        S_RDA,
        S_RDB,
        S_DIF,
        S_RAD,
        S_RADW,
        S_UMAG,
        S_UCHK,
        S_UNORM,
        S_USQ,
        S_USQW,
        S_USQRT,
        S_USQRTW,
        S_UDIV,
        S_UDIVW,
        S_URET,
        S_KSEL,
        S_XMUL,
        S_XACC,
        S_YMUL1,
        S_YMUL2,
        S_YACC,
        S_PSM,
        S_PMUL,
        S_PMULW,
        S_RND1,
        S_RND2,
        S_RND3,
        S_DEG,
        S_DONE
    } t_state;

endpackage

// File: hdl/epp_in_if.sv
// Input channel: one operand word per handshake.
interface epp_in_if #(parameter int WORD_BITS = 48);
    logic                                valid;
    logic                                ready;
    logic [epp_pkg::SLOT_BITS-1:0]       slot;
    logic signed [WORD_BITS-1:0]         operand_value;
    logic                                last;

    modport source (output valid, slot, operand_value, last, input ready);
    modport sink   (input valid, slot, operand_value, last, output ready);
endinterface

// File: hdl/epp_out_if.sv
// Output channel: one projected encounter word per handshake.
interface epp_out_if #(parameter int WORD_BITS = 48);
    logic                        valid;
    logic                        ready;
    logic signed [WORD_BITS-1:0] miss_x;
    logic signed [WORD_BITS-1:0] miss_y;
    logic signed [WORD_BITS-1:0] var_xx;
    logic signed [WORD_BITS-1:0] cov_xy;
    logic signed [WORD_BITS-1:0] var_yy;
    logic signed [WORD_BITS-1:0] radius_out;
    logic                        degenerate;

    modport source (output valid, miss_x, miss_y, var_xx, cov_xy, var_yy, radius_out,
                    degenerate, input ready);
    modport sink   (input valid, miss_x, miss_y, var_xx, cov_xy, var_yy, radius_out,
                    degenerate, output ready);
endinterface

// File: hdl/epp_mul.sv
// Bit-serial signed 64x64 multiplier, 128-bit product, one partial product per cycle.
module epp_mul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  epp_pkg::t_mul_req i_req,
    output epp_pkg::t_mul_rsp o_rsp
);
    import epp_pkg::*;

    logic [127:0] r_acc;
    logic [127:0] r_ash;
    logic [63:0]  r_b;
    logic         r_neg;
    logic [5:0]   r_cnt;
    logic         r_busy;
    logic         r_fin;
    logic         r_done;
    t_s128        r_p;
    logic [63:0]  ma;
    logic [63:0]  mb;

    assign ma = i_req.a[63] ? 64'(-i_req.a) : 64'(i_req.a);
    assign mb = i_req.b[63] ? 64'(-i_req.b) : 64'(i_req.b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_ash  <= {64'd0, ma};
                r_b    <= mb;
                r_neg  <= i_req.a[63] ^ i_req.b[63];
                r_acc  <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_b[0]) begin
                    r_acc <= r_acc + r_ash;
                end
                r_ash <= r_ash << 1;
                r_b   <= r_b >> 1;
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end else if (r_fin) begin
                r_p    <= r_neg ? -t_s128'(r_acc) : t_s128'(r_acc);
                r_fin  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.p    = r_p;
endmodule

// File: hdl/epp_sqdiv.sv
// Shared square-root / divide unit: restoring, one root bit or quotient bit per cycle.
module epp_sqdiv (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  epp_pkg::t_sd_req i_req,
    output epp_pkg::t_sd_rsp o_rsp
);
    import epp_pkg::*;

    logic [127:0] r_src;
    logic [67:0]  r_rem;
    logic [63:0]  r_res;
    logic [63:0]  r_den;
    logic [6:0]   r_cnt;
    logic         r_busy;
    logic         r_div;
    logic         r_done;
    logic [67:0]  rem_sh;
    logic [67:0]  trial;
    logic         take;
    logic [6:0]   last_cnt;

    always_comb begin
        if (r_div) begin
            rem_sh   = {r_rem[66:0], r_src[127]};
            trial    = {4'd0, r_den};
            last_cnt = 7'd127;
        end else begin
            rem_sh   = {r_rem[65:0], r_src[127:126]};
            trial    = {2'd0, r_res, 2'b01};
            last_cnt = 7'd63;
        end
        take = rem_sh >= trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_src  <= i_req.src;
                r_den  <= i_req.den;
                r_div  <= i_req.is_div;
                r_rem  <= '0;
                r_res  <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= take ? rem_sh - trial : rem_sh;
                r_res <= {r_res[62:0], take};
                r_src <= r_div ? (r_src << 1) : (r_src << 2);
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == last_cnt) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_res;
endmodule

// File: hdl/encounter_plane_projection.sv
// Each operand word is stored as it is accepted; a word with last set starts a
// computation, and the result word is offered when it completes.
// While loading, one word is taken per cycle (ready is high only in idle); the
// computation time is set by the bit-serial multiplier and the square-root / divide unit.
// Reset clears control state only; operand store entries hold no value until loaded.
module encounter_plane_projection #(
    parameter int FRAC_BITS = 24,
    parameter int WORD_BITS = 48
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    epp_in_if.sink    i_in,
    epp_out_if.source o_out
);
    import epp_pkg::*;

    localparam t_s64        WMAX      = (64'sd1 <<< (WORD_BITS - 1)) - 64'sd1;
    localparam t_s64        WMIN      = -WMAX - 64'sd1;
    localparam logic [63:0] MIN_MAG   = 64'd1 << (WORD_BITS - 1);
    localparam logic [63:0] MICRO_VAR =
        64'(((64'd1 << FRAC_BITS) + 64'd500000) / 64'd1000000);
    localparam logic [127:0] HALF_P   = 128'd1 << (UNIT_BITS - 1);
    localparam logic [127:0] HALF_Q   = 128'd1 << (2 * UNIT_BITS - 1);
    localparam t_s32        UNIT_ONE  = 32'sd1 <<< UNIT_BITS;

    // operand store
    logic signed [WORD_BITS-1:0] r_mem [SLOT_COUNT];
    logic signed [WORD_BITS-1:0] r_rd;
    logic [SLOT_BITS-1:0]        rd_addr;

    t_state      r_state, n_state;
    t_pass       r_pass;
    logic [3:0]  r_j;
    logic [1:0]  r_idx, r_ti, r_tj;
    logic [2:0]  r_o;
    t_s64        r_opa;
    t_s64        r_ops [PAIR_COUNT];
    t_s64        r_vec [3];
    logic [63:0] r_m   [3];
    t_s32        r_u   [3];
    t_s32        r_z   [3];
    t_s32        r_x   [3];
    t_s32        r_y   [3];
    logic        r_k;
    logic        r_uzero;
    t_u128       r_sum;
    logic [63:0] r_root;
    t_s64        r_prod, r_prod2;
    logic        r_neg;
    logic [63:0] r_mag;
    logic signed [WORD_BITS-1:0] r_w [5];
    logic signed [WORD_BITS-1:0] r_rad;
    logic        r_degen;

    logic signed [WORD_BITS-1:0] r_q [5];
    logic signed [WORD_BITS-1:0] r_q_rad;
    logic        r_q_deg;
    logic        r_ov;

    t_mul_req mul_req;
    t_mul_rsp mul_rsp;
    t_sd_req  sd_req;
    t_sd_rsp  sd_rsp;

    t_s32         sm_a, sm_b;
    t_s64         p_small;
    logic         in_acc, out_acc, out_load;
    logic         m_zero, m_small;
    logic [3:0]   cidx;
    logic [35:0]  z0x10;
    logic [127:0] rnd_add, rnd_shr;
    logic [63:0]  rnd_lim;

    function automatic logic [SLOT_BITS-1:0] pair_a(input logic [3:0] j);
        return (j < 4'd6) ? SLOT_BITS'(j) : SLOT_BITS'(j) + SLOT_BITS'(6);
    endfunction

    function automatic logic [SLOT_BITS-1:0] pair_b(input logic [3:0] j);
        return (j < 4'd6) ? SLOT_BITS'(j) + SLOT_BITS'(6) : SLOT_BITS'(j) + SLOT_BITS'(15);
    endfunction

    function automatic logic [1:0] nxt3(input logic [1:0] i);
        return (i == 2'd2) ? 2'd0 : i + 2'd1;
    endfunction

    function automatic t_s64 sat_word(input logic signed [64:0] s);
        if (s > 65'(WMAX)) return WMAX;
        if (s < 65'(WMIN)) return WMIN;
        return s[63:0];
    endfunction

    // round to nearest, ties away from zero, drop UNIT_BITS fraction bits
    function automatic t_s64 rnd_unit(input t_s64 v);
        logic [63:0] m;
        m = v[63] ? 64'(-v) : 64'(v);
        m = (m + (64'd1 << (UNIT_BITS - 1))) >> UNIT_BITS;
        return v[63] ? -t_s64'(m) : t_s64'(m);
    endfunction

    epp_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    epp_sqdiv u_sqdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (sd_req),
        .o_rsp   (sd_rsp)
    );

    assign i_in.ready = (r_state == S_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;
    assign out_acc    = o_out.valid && o_out.ready;
    assign out_load   = (r_state == S_DONE) && (!r_ov || o_out.ready);

    assign m_zero  = (r_m[0] == 64'd0) && (r_m[1] == 64'd0) && (r_m[2] == 64'd0);
    assign m_small = (r_m[0][63:NORM_BITS] == '0) && (r_m[1][63:NORM_BITS] == '0) &&
                     (r_m[2][63:NORM_BITS] == '0);
    assign cidx    = {1'b0, r_ti, 1'b0} + {2'b0, r_ti} + {2'b0, r_tj};
    assign z0x10   = ({4'd0, (r_z[0][31] ? 32'(-r_z[0]) : 32'(r_z[0]))} << 3) +
                     ({4'd0, (r_z[0][31] ? 32'(-r_z[0]) : 32'(r_z[0]))} << 1);
    assign p_small = sm_a * sm_b;

    assign rnd_add = r_sum + ((r_o < 3'd2) ? HALF_P : HALF_Q);
    assign rnd_shr = (r_o < 3'd2) ? (rnd_add >> UNIT_BITS) : (rnd_add >> (2 * UNIT_BITS));
    assign rnd_lim = r_neg ? MIN_MAG : MIN_MAG - 64'd1;

    always_ff @(posedge i_clk) begin
        if (in_acc && (i_in.slot < SLOT_BITS'(SLOT_COUNT))) begin
            r_mem[i_in.slot] <= i_in.operand_value;
        end
        r_rd <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        rd_addr = '0;
        mul_req = '0;
        sd_req  = '0;
        sm_a    = '0;
        sm_b    = '0;
        case (r_state)
            S_IDLE: begin
                if (in_acc && i_in.last) n_state = S_RDA;
            end
            S_RDA: begin
                rd_addr = pair_a(r_j);
                n_state = S_RDB;
            end
            S_RDB: begin
                rd_addr = pair_b(r_j);
                n_state = S_DIF;
            end
            S_DIF: begin
                n_state = (r_j == 4'(PAIR_COUNT - 1)) ? S_RAD : S_RDA;
            end
            S_RAD: begin
                rd_addr = SLOT_BITS'(RAD_SLOT);
                n_state = S_RADW;
            end
            S_RADW:  n_state = S_UMAG;
            S_UMAG:  n_state = S_UCHK;
            S_UCHK:  n_state = m_zero ? S_URET : S_UNORM;
            S_UNORM: begin
                if (!m_small) n_state = S_USQ;
            end
            S_USQ: begin
                mul_req.start = 1'b1;
                mul_req.a     = t_s64'(r_m[r_idx]);
                mul_req.b     = t_s64'(r_m[r_idx]);
                n_state       = S_USQW;
            end
            S_USQW: begin
                if (mul_rsp.done) n_state = (r_idx == 2'd2) ? S_USQRT : S_USQ;
            end
            S_USQRT: begin
                sd_req.start = 1'b1;
                sd_req.src   = r_sum;
                n_state      = S_USQRTW;
            end
            S_USQRTW: begin
                if (sd_rsp.done) n_state = (r_pass == PASS_DEG) ? S_DEG : S_UDIV;
            end
            S_UDIV: begin
                sd_req.start  = 1'b1;
                sd_req.is_div = 1'b1;
                sd_req.src    = ({64'd0, r_m[r_idx]} << UNIT_BITS) + {65'd0, r_root[63:1]};
                sd_req.den    = r_root;
                n_state       = S_UDIVW;
            end
            S_UDIVW: begin
                if (sd_rsp.done) n_state = (r_idx == 2'd2) ? S_URET : S_UDIV;
            end
            S_URET: begin
                if (r_pass == PASS_Z) begin
                    n_state = r_uzero ? S_USQ : S_KSEL;
                end else begin
                    n_state = S_YMUL1;
                end
            end
            S_KSEL: n_state = S_XMUL;
            S_XMUL: begin
                sm_a    = r_k ? r_z[1] : r_z[0];
                sm_b    = r_z[r_idx];
                n_state = S_XACC;
            end
            S_XACC: n_state = (r_idx == 2'd2) ? S_UMAG : S_XMUL;
            S_YMUL1: begin
                sm_a    = r_z[nxt3(r_idx)];
                sm_b    = r_x[nxt3(nxt3(r_idx))];
                n_state = S_YMUL2;
            end
            S_YMUL2: begin
                sm_a    = r_z[nxt3(nxt3(r_idx))];
                sm_b    = r_x[nxt3(r_idx)];
                n_state = S_YACC;
            end
            S_YACC: n_state = (r_idx == 2'd2) ? S_PSM : S_YMUL1;
            S_PSM: begin
                sm_a    = (r_o == 3'd4) ? r_y[r_ti] : r_x[r_ti];
                sm_b    = (r_o == 3'd2) ? r_x[r_tj] : r_y[r_tj];
                n_state = S_PMUL;
            end
            S_PMUL: begin
                mul_req.start = 1'b1;
                if (r_o < 3'd2) begin
                    mul_req.a = r_ops[r_tj];
                    mul_req.b = t_s64'((r_o == 3'd0) ? r_x[r_tj] : r_y[r_tj]);
                end else begin
                    mul_req.a = r_ops[4'd6 + cidx];
                    mul_req.b = r_prod;
                end
                n_state = S_PMULW;
            end
            S_PMULW: begin
                if (mul_rsp.done) begin
                    if (r_tj == 2'd2 && (r_o < 3'd2 || r_ti == 2'd2)) n_state = S_RND1;
                    else n_state = S_PSM;
                end
            end
            S_RND1: n_state = S_RND2;
            S_RND2: n_state = S_RND3;
            S_RND3: n_state = (r_o == 3'd4) ? S_DONE : S_PSM;
            S_DEG:  n_state = S_DONE;
            S_DONE: begin
                if (out_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: r_j <= '0;
            S_RDB:  r_opa <= t_s64'(r_rd);
            S_DIF: begin
                if (r_j < 4'd6) r_ops[r_j] <= sat_word(65'(r_opa) - 65'(t_s64'(r_rd)));
                else            r_ops[r_j] <= sat_word(65'(r_opa) + 65'(t_s64'(r_rd)));
                r_j <= r_j + 4'd1;
            end
            S_RADW: begin
                r_rad   <= r_rd;
                r_degen <= 1'b0;
                r_pass  <= PASS_Z;
                for (int i = 0; i < 3; i++) r_vec[i] <= r_ops[3 + i];
            end
            S_UMAG: begin
                for (int i = 0; i < 3; i++) begin
                    r_m[i] <= r_vec[i][63] ? 64'(-r_vec[i]) : 64'(r_vec[i]);
                end
            end
            S_UCHK: r_uzero <= m_zero;
            S_UNORM: begin
                if (m_small) begin
                    for (int i = 0; i < 3; i++) r_m[i] <= r_m[i] << 1;
                end else begin
                    r_idx <= '0;
                    r_sum <= '0;
                end
            end
            S_USQW: begin
                if (mul_rsp.done) begin
                    r_sum <= r_sum + t_u128'(mul_rsp.p);
                    r_idx <= (r_idx == 2'd2) ? 2'd0 : r_idx + 2'd1;
                end
            end
            S_USQRTW: begin
                if (sd_rsp.done) begin
                    r_root <= sd_rsp.res;
                    r_idx  <= '0;
                end
            end
            S_UDIVW: begin
                if (sd_rsp.done) begin
                    r_u[r_idx] <= r_vec[r_idx][63] ? -t_s32'(sd_rsp.res[31:0])
                                                   : t_s32'(sd_rsp.res[31:0]);
                    r_idx      <= (r_idx == 2'd2) ? 2'd0 : r_idx + 2'd1;
                end
            end
            S_URET: begin
                if (r_pass == PASS_Z) begin
                    if (r_uzero) begin
                        // stopped relative motion: |dr| through the same square/root path
                        for (int i = 0; i < 3; i++) begin
                            r_m[i] <= r_ops[i][63] ? 64'(-r_ops[i]) : 64'(r_ops[i]);
                        end
                        r_sum  <= '0;
                        r_idx  <= '0;
                        r_pass <= PASS_DEG;
                    end else begin
                        for (int i = 0; i < 3; i++) r_z[i] <= r_u[i];
                    end
                end else begin
                    for (int i = 0; i < 3; i++) r_x[i] <= r_uzero ? r_vec[i][31:0] : r_u[i];
                    r_idx <= '0;
                end
            end
            S_KSEL: begin
                r_k   <= z0x10 > (36'd9 << UNIT_BITS);
                r_idx <= '0;
            end
            S_XMUL: r_prod <= p_small;
            S_XACC: begin
                r_vec[r_idx] <= t_s64'((((r_k ? 2'd1 : 2'd0) == r_idx) ? UNIT_ONE : 32'sd0)
                                - t_s32'(rnd_unit(r_prod)));
                r_idx <= (r_idx == 2'd2) ? 2'd0 : r_idx + 2'd1;
                if (r_idx == 2'd2) r_pass <= PASS_X;
            end
            S_YMUL1: r_prod  <= p_small;
            S_YMUL2: r_prod2 <= p_small;
            S_YACC: begin
                r_y[r_idx] <= t_s32'(rnd_unit(r_prod - r_prod2));
                r_idx      <= (r_idx == 2'd2) ? 2'd0 : r_idx + 2'd1;
                r_o        <= '0;
                r_ti       <= '0;
                r_tj       <= '0;
                r_sum      <= '0;
            end
            S_PSM: r_prod <= p_small;
            S_PMULW: begin
                if (mul_rsp.done) begin
                    r_sum <= r_sum + t_u128'(mul_rsp.p);
                    if (r_tj == 2'd2) begin
                        r_tj <= '0;
                        r_ti <= (r_ti == 2'd2) ? 2'd0 : r_ti + 2'd1;
                    end else begin
                        r_tj <= r_tj + 2'd1;
                    end
                end
            end
            S_RND1: begin
                r_neg <= r_sum[127];
                r_sum <= r_sum[127] ? -r_sum : r_sum;
                r_ti  <= '0;
            end
            S_RND2: begin
                r_mag <= (rnd_shr > {64'd0, rnd_lim}) ? rnd_lim : rnd_shr[63:0];
            end
            S_RND3: begin
                r_w[r_o] <= WORD_BITS'(r_neg ? -r_mag : r_mag);
                r_o      <= r_o + 3'd1;
                r_ti     <= '0;
                r_tj     <= '0;
                r_sum    <= '0;
            end
            S_DEG: begin
                r_w[0]  <= WORD_BITS'((r_root > 64'(WMAX)) ? 64'(WMAX) : r_root);
                r_w[1]  <= '0;
                r_w[2]  <= WORD_BITS'(MICRO_VAR);
                r_w[3]  <= '0;
                r_w[4]  <= WORD_BITS'(MICRO_VAR);
                r_degen <= 1'b1;
            end
            default: ;
        endcase
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_load) begin
            r_ov <= 1'b1;
        end else if (out_acc) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            for (int i = 0; i < 5; i++) r_q[i] <= r_w[i];
            r_q_rad <= r_rad;
            r_q_deg <= r_degen;
        end
    end

    assign o_out.valid      = r_ov;
    assign o_out.miss_x     = r_q[0];
    assign o_out.miss_y     = r_q[1];
    assign o_out.var_xx     = r_q[2];
    assign o_out.cov_xy     = r_q[3];
    assign o_out.var_yy     = r_q[4];
    assign o_out.radius_out = r_q_rad;
    assign o_out.degenerate = r_q_deg;
endmodule
